>>> rtl/rfpf_pkg.sv
package rfpf_pkg;

    // configuration register widths and indexes
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int POLE_TGT_W  = 23;
    localparam int FB_TGT_W    = 24;
    localparam int KEEP_W      = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_POLE_TGT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_TGT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP     = 2'd2;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 23'd3950700;

    // internal word width of stage values and coefficients
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;

    // microcode sequencer
    localparam int STEP_W  = 5;
    localparam int N_STEPS = 24;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        OPA_FB,
        OPA_ST4,
        OPA_GIN,
        OPA_PREV,
        OPA_ST0,
        OPA_POLE,
        OPA_PT,
        OPA_FT
    } t_opa;

    typedef enum logic [2:0] {
        OPB_K,
        OPB_FB,
        OPB_X,
        OPB_G,
        OPB_P,
        OPB_KEEP,
        OPB_CKEEP
    } t_opb;

    typedef enum logic [1:0] {
        DST_GIN,
        DST_STAGE,
        DST_POLE,
        DST_FB
    } t_dest;

    typedef struct packed {
        logic  issue;
        t_opa  a_sel;
        t_opb  b_sel;
        logic  sub;
        logic  first;
        logic  last;
        logic  bias;
        t_dest dest;
    } t_uop;

    function automatic t_uop mk_uop(input t_opa a, input t_opb b, input logic sub,
                                    input logic first, input logic last,
                                    input logic bias, input t_dest dest);
        t_uop u;
        u.issue = 1'b1;
        u.a_sel = a;
        u.b_sel = b;
        u.sub   = sub;
        u.first = first;
        u.last  = last;
        u.bias  = bias;
        u.dest  = dest;
        return u;
    endfunction

    // one product per step; empty slots let the stage shift line settle
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{issue: 1'b0, a_sel: OPA_FB, b_sel: OPB_K, sub: 1'b0, first: 1'b0,
              last: 1'b0, bias: 1'b0, dest: DST_GIN};
        case (step)
            5'd0:  u = mk_uop(OPA_FB,   OPB_K,     1'b0, 1'b1, 1'b1, 1'b1, DST_GIN);
            5'd1:  u = mk_uop(OPA_ST4,  OPB_FB,    1'b1, 1'b1, 1'b0, 1'b0, DST_STAGE);
            5'd2:  u = mk_uop(OPA_GIN,  OPB_X,     1'b0, 1'b0, 1'b1, 1'b0, DST_STAGE);
            5'd4, 5'd8, 5'd12, 5'd16:
                   u = mk_uop(OPA_PREV, OPB_G,     1'b0, 1'b1, 1'b0, 1'b0, DST_STAGE);
            5'd5, 5'd9, 5'd13, 5'd17:
                   u = mk_uop(OPA_ST0,  OPB_P,     1'b1, 1'b0, 1'b0, 1'b0, DST_STAGE);
            5'd6, 5'd10, 5'd14, 5'd18:
                   u = mk_uop(OPA_ST4,  OPB_G,     1'b0, 1'b0, 1'b1, 1'b0, DST_STAGE);
            5'd19: u = mk_uop(OPA_POLE, OPB_KEEP,  1'b0, 1'b1, 1'b0, 1'b0, DST_POLE);
            5'd20: u = mk_uop(OPA_PT,   OPB_CKEEP, 1'b0, 1'b0, 1'b1, 1'b0, DST_POLE);
            5'd21: u = mk_uop(OPA_FB,   OPB_KEEP,  1'b0, 1'b1, 1'b0, 1'b0, DST_FB);
            5'd22: u = mk_uop(OPA_FT,   OPB_CKEEP, 1'b0, 1'b0, 1'b1, 1'b0, DST_FB);
            default: ;
        endcase
        return u;
    endfunction

endpackage

>>> rtl/resonant_four_pole_filter_unit.sv
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_stall  | i_sample, i_snap
// out     | output    | o_valid / i_stall  | o_filtered
// cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// a word runs from accept through 24 sequencer steps on the single 32x32
// multiplier (19 products, 4 empty slots while the stage shift line moves, one
// drain step), then the done state loads the output register and the idle state
// opens the input again. synchronous active-low reset clears stage state, pole,
// feedback and targets, but sets gain to one half and keep to KEEP_RESET.
// a stalled output word holds the sequencer in its done state until it is taken.
module resonant_four_pole_filter_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_snap,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_filtered,
    input  logic                                i_cfg_we,
    input  logic [rfpf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rfpf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rfpf_pkg::*;

    localparam int ACC_W = PROD_W - COEF_FRAC_BITS + 2;
    localparam longint K_FULL = ((64'sd1075 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam logic signed [WORD_W-1:0] K1075 = WORD_W'(K_FULL);
    localparam logic signed [WORD_W-1:0] ONE = 32'sd1 <<< COEF_FRAC_BITS;
    localparam logic signed [WORD_W-1:0] HALF = 32'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(32'sh80000000);
    localparam logic signed [WORD_W-1:0] OUT_HI =
        WORD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WORD_W-1:0] OUT_LO = -OUT_HI - 32'sd1;

    t_state r_state;
    logic [STEP_W-1:0] r_step;

    logic signed [POLE_TGT_W-1:0] r_pole_tgt;
    logic [FB_TGT_W-1:0]          r_fb_tgt;
    logic [KEEP_W-1:0]            r_keep;

    logic signed [WORD_W-1:0] r_st [5];
    logic signed [WORD_W-1:0] r_prev;
    logic signed [WORD_W-1:0] r_pole;
    logic signed [WORD_W-1:0] r_fb;
    logic signed [WORD_W-1:0] r_gain;
    logic signed [WORD_W-1:0] r_gin;
    logic signed [SAMPLE_BITS-1:0] r_x;

    t_uop                     r_puop;
    logic                     r_pv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;

    t_uop                     uop;
    logic signed [WORD_W-1:0] op_a;
    logic signed [WORD_W-1:0] op_b;
    logic signed [PROD_W-1:0] mul;
    logic signed [PROD_W-1:0] rnd;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [WORD_W-1:0] res;
    logic signed [WORD_W+1:0] pole_sum;
    logic signed [WORD_W+1:0] snap_sum;
    logic signed [WORD_W-1:0] ckeep;
    logic signed [WORD_W-1:0] out_sat;
    logic                     accept;
    logic                     out_free;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid    = r_out_valid;
    assign o_filtered = r_filtered;

    assign uop   = ucode(r_step);
    assign ckeep = ONE - $signed(WORD_W'(r_keep));

    always_comb begin
        case (uop.a_sel)
            OPA_FB:   op_a = r_fb;
            OPA_ST4:  op_a = r_st[4];
            OPA_GIN:  op_a = r_gin;
            OPA_PREV: op_a = r_prev;
            OPA_ST0:  op_a = r_st[0];
            OPA_POLE: op_a = r_pole;
            OPA_PT:   op_a = WORD_W'(r_pole_tgt);
            OPA_FT:   op_a = $signed(WORD_W'(r_fb_tgt));
            default:  op_a = r_fb;
        endcase
        case (uop.b_sel)
            OPB_K:     op_b = K1075;
            OPB_FB:    op_b = r_fb;
            OPB_X:     op_b = WORD_W'(r_x);
            OPB_G:     op_b = r_gain;
            OPB_P:     op_b = r_pole;
            OPB_KEEP:  op_b = $signed(WORD_W'(r_keep));
            OPB_CKEEP: op_b = ckeep;
            default:   op_b = K1075;
        endcase
    end

    assign mul = op_a * op_b;

    // round half up, then floor shift back to the operand scale
    always_comb begin
        rnd      = (r_prod + ROUND_HALF) >>> COEF_FRAC_BITS;
        term     = $signed(rnd[ACC_W-1:0]);
        acc_base = r_puop.first ? (r_puop.bias ? ACC_W'(ONE) : '0) : r_acc;
        n_acc    = r_puop.sub ? (acc_base - term) : (acc_base + term);
        if (n_acc > ACC_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (n_acc < ACC_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = n_acc[WORD_W-1:0];
        end
    end

    // gain follows (pole + 1) / 2, rounded
    assign pole_sum = (WORD_W+2)'(r_pole) + (WORD_W+2)'(ONE) + (WORD_W+2)'(1);
    assign snap_sum = (WORD_W+2)'(r_pole_tgt) + (WORD_W+2)'(ONE) + (WORD_W+2)'(1);

    always_comb begin
        if (r_st[4] > OUT_HI) begin
            out_sat = OUT_HI;
        end else if (r_st[4] < OUT_LO) begin
            out_sat = OUT_LO;
        end else begin
            out_sat = r_st[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_tgt <= '0;
            r_fb_tgt   <= '0;
            r_keep     <= KEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLE_TGT: r_pole_tgt <= $signed(i_cfg_data[POLE_TGT_W-1:0]);
                CFG_FB_TGT:   r_fb_tgt   <= i_cfg_data[FB_TGT_W-1:0];
                CFG_KEEP:     r_keep     <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= (r_state == ST_RUN) && uop.issue;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_step  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload and datapath state
    always_ff @(posedge i_clk) begin
        r_puop <= uop;
        r_prod <= mul;
        if (r_state == ST_DONE && out_free) begin
            r_filtered <= out_sat[SAMPLE_BITS-1:0];
        end
        if (accept) begin
            r_x <= i_sample;
        end
        if (r_pv) begin
            r_acc <= n_acc;
        end
        if (r_pv && r_puop.last && r_puop.dest == DST_GIN) begin
            r_gin <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_st[k] <= '0;
            end
            r_prev <= '0;
            r_pole <= '0;
            r_fb   <= '0;
            r_gain <= HALF;
        end else if (accept && i_snap) begin
            r_pole <= WORD_W'(r_pole_tgt);
            r_fb   <= $signed(WORD_W'(r_fb_tgt));
            r_gain <= snap_sum[WORD_W:1];
        end else if (r_pv && r_puop.last) begin
            case (r_puop.dest)
                // stage values move down the shift line, newest at the top
                DST_STAGE: begin
                    r_prev <= r_st[0];
                    for (int k = 0; k < 4; k++) begin
                        r_st[k] <= r_st[k+1];
                    end
                    r_st[4] <= res;
                end
                DST_POLE: begin
                    r_gain <= pole_sum[WORD_W:1];
                    r_pole <= res;
                end
                DST_FB: r_fb <= res;
                default: ;
            endcase
        end
    end

endmodule
